FILE: rtl/core/xte_pkg.sv
// Shared types, constants and helper functions of the XML text escaper.
package xte_pkg;

  localparam int MaxSeqBytesDef = 6;
  localparam int BcdDigits      = 10;
  localparam int BcdW           = 4 * BcdDigits;

  localparam logic [7:0] ChAmp   = 8'h26;
  localparam logic [7:0] ChLt    = 8'h3C;
  localparam logic [7:0] ChGt    = 8'h3E;
  localparam logic [7:0] ChDq    = 8'h22;
  localparam logic [7:0] ChSq    = 8'h27;
  localparam logic [7:0] ChHash  = 8'h23;
  localparam logic [7:0] ChSemi  = 8'h3B;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] PrintLo = 8'd32;

  localparam logic [47:0] EntAmp  = "&amp;";
  localparam logic [47:0] EntLt   = "&lt;";
  localparam logic [47:0] EntGt   = "&gt;";
  localparam logic [47:0] EntQuot = "&quot;";
  localparam logic [47:0] EntApos = "&apos;";

  typedef logic [BcdW-1:0] bcd_t;

  typedef enum logic [1:0] {
    QM_ELEMENT = 2'd0,
    QM_DQUOTE  = 2'd1,
    QM_SQUOTE  = 2'd2,
    QM_OTHER   = 2'd3
  } xte_qmode_e;

  typedef enum logic [2:0] {
    KIND_TEXT,
    KIND_AMP,
    KIND_LT,
    KIND_GT,
    KIND_QUOT,
    KIND_APOS,
    KIND_REF,
    KIND_MARK
  } xte_kind_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       text_last;
  } xte_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       run_last;
    logic       text_end;
    logic       error;
  } xte_out_t;

  typedef struct packed {
    xte_kind_e  kind;
    logic [7:0] text;
    bcd_t       bcd;
    logic       text_last;
    logic       err;
  } xte_job_t;

  // shift six binary bits into a BCD number, double-dabble style
  function automatic bcd_t bcd_push6(bcd_t v, logic [5:0] bits);
    bcd_t r;
    r = v;
    for (int s = 5; s >= 0; s--) begin
      for (int d = 0; d < BcdDigits; d++) begin
        if (r[4*d +: 4] >= 4'd5) r[4*d +: 4] = r[4*d +: 4] + 4'd3;
      end
      r = {r[BcdW-2:0], bits[s]};
    end
    return r;
  endfunction

  // count of leading one bits of a byte
  function automatic logic [3:0] lead_ones(logic [7:0] b);
    logic [3:0] n;
    logic       run;
    n   = '0;
    run = 1'b1;
    for (int i = 7; i >= 0; i--) begin
      if (run && b[i]) n = n + 4'd1;
      else run = 1'b0;
    end
    return n;
  endfunction

  // number of decimal digits in use, at least one
  function automatic logic [3:0] bcd_ndig(bcd_t v);
    logic [3:0] n;
    n = 4'd1;
    for (int d = 1; d < BcdDigits; d++) begin
      if (v[4*d +: 4] != 4'd0) n = 4'(d + 1);
    end
    return n;
  endfunction

  function automatic logic [3:0] job_len(xte_kind_e k, logic [3:0] ndig);
    logic [3:0] n;
    unique case (k)
      KIND_AMP:             n = 4'd5;
      KIND_LT, KIND_GT:     n = 4'd4;
      KIND_QUOT, KIND_APOS: n = 4'd6;
      KIND_REF:             n = ndig + 4'd3;
      default:              n = 4'd1;
    endcase
    return n;
  endfunction

  // character at position idx of a named entity of length len
  function automatic logic [7:0] ent_char(xte_kind_e k, logic [3:0] idx, logic [3:0] len);
    logic [47:0] s;
    logic [2:0]  pos;
    unique case (k)
      KIND_AMP:  s = EntAmp;
      KIND_LT:   s = EntLt;
      KIND_GT:   s = EntGt;
      KIND_QUOT: s = EntQuot;
      default:   s = EntApos;
    endcase
    pos = 3'(len - 4'd1 - idx);
    return s[8*pos +: 8];
  endfunction

endpackage

FILE: rtl/core/xte_decode.sv
// Per-byte classification and UTF-8 gathering state of the XML text escaper.
module xte_decode
  import xte_pkg::*;
#(
  parameter int MaxSeqBytes = MaxSeqBytesDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_wdata_i,
  input  xte_in_t    in_word_i,
  input  logic       accept_i,
  output logic       job_valid_o,
  output xte_job_t   job_o
);

  xte_qmode_e qmode_q;
  logic [2:0] pend_q, pend_d;
  bcd_t       bcd_q, bcd_d;
  logic       err_q, err_d;

  logic [7:0] b;
  logic       last;
  logic [3:0] lead_n;
  logic [7:0] lead_bits;

  assign b         = in_word_i.in_byte;
  assign last      = in_word_i.text_last;
  assign lead_n    = lead_ones(b);
  assign lead_bits = b & (8'hFF >> ({1'b0, lead_n} + 5'd1));

  always_comb begin
    pend_d          = pend_q;
    bcd_d           = bcd_q;
    err_d           = err_q;
    job_valid_o     = 1'b0;
    job_o.kind      = KIND_TEXT;
    job_o.text      = b;
    job_o.bcd       = '0;
    job_o.text_last = last;
    job_o.err       = 1'b0;
    if (accept_i) begin
      priority if (err_q) begin
        // rest of text ignored
      end else if (pend_q != 3'd0) begin
        bcd_d  = bcd_push6(bcd_q, b[5:0]);
        pend_d = pend_q - 3'd1;
        if (pend_q == 3'd1) begin
          job_valid_o = 1'b1;
          job_o.kind  = KIND_REF;
          job_o.bcd   = bcd_d;
        end else if (last) begin
          err_d = 1'b1;
        end
      end else if (b == ChAmp) begin
        job_valid_o = 1'b1;
        job_o.kind  = KIND_AMP;
      end else if (b == ChLt) begin
        job_valid_o = 1'b1;
        job_o.kind  = KIND_LT;
      end else if (b == ChGt) begin
        job_valid_o = 1'b1;
        job_o.kind  = KIND_GT;
      end else if (b == ChDq && qmode_q != QM_ELEMENT) begin
        if (qmode_q == QM_DQUOTE) begin
          job_valid_o = 1'b1;
          job_o.kind  = KIND_QUOT;
        end else if (qmode_q == QM_SQUOTE) begin
          job_valid_o = 1'b1;
        end
      end else if (b == ChSq && qmode_q != QM_ELEMENT) begin
        if (qmode_q == QM_SQUOTE) begin
          job_valid_o = 1'b1;
          job_o.kind  = KIND_APOS;
        end else if (qmode_q == QM_DQUOTE) begin
          job_valid_o = 1'b1;
        end
      end else if (b >= PrintLo && !b[7]) begin
        job_valid_o = 1'b1;
      end else if (b < PrintLo) begin
        job_valid_o = 1'b1;
        job_o.kind  = KIND_REF;
        job_o.bcd   = bcd_push6('0, b[5:0]);
      end else begin
        if (lead_n < 4'd2 || lead_n > 4'(MaxSeqBytes) || last) begin
          err_d = 1'b1;
        end else begin
          bcd_d  = bcd_push6('0, lead_bits[5:0]);
          pend_d = 3'(lead_n - 4'd1);
        end
      end
      if (last) begin
        if (!job_valid_o) begin
          job_valid_o = 1'b1;
          job_o.kind  = KIND_MARK;
          job_o.err   = err_d;
        end
        pend_d = '0;
        bcd_d  = '0;
        err_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qmode_q <= QM_ELEMENT;
      pend_q  <= '0;
      bcd_q   <= '0;
      err_q   <= 1'b0;
    end else begin
      if (cfg_we_i) qmode_q <= xte_qmode_e'(cfg_wdata_i);
      pend_q <= pend_d;
      bcd_q  <= bcd_d;
      err_q  <= err_d;
    end
  end

endmodule

FILE: rtl/core/xte_emit.sv
// Output sequencer: walks one escape job and drives the registered output word.
module xte_emit
  import xte_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     job_load_i,
  input  xte_job_t job_i,
  output logic     free_o,
  input  logic     out_ready_i,
  output logic     out_valid_o,
  output xte_out_t out_word_o
);

  xte_job_t   job_q;
  logic       job_valid_q;
  logic [3:0] idx_q;
  logic       out_valid_q;
  xte_out_t   out_q;

  logic [3:0] ndig;
  logic [3:0] len;
  logic [3:0] dpos;
  logic       load_out;
  logic       step;
  logic       last_byte;
  xte_out_t   word_d;

  assign ndig      = bcd_ndig(job_q.bcd);
  assign len       = job_len(job_q.kind, ndig);
  assign dpos      = ndig + 4'd1 - idx_q;
  assign load_out  = !out_valid_q || out_ready_i;
  assign step      = job_valid_q && load_out;
  assign last_byte = (idx_q == len - 4'd1);
  assign free_o    = !job_valid_q || (step && last_byte);

  always_comb begin
    word_d.byte_valid = 1'b1;
    word_d.run_last   = last_byte;
    word_d.text_end   = last_byte && job_q.text_last;
    word_d.error      = 1'b0;
    unique case (job_q.kind)
      KIND_TEXT: word_d.out_byte = job_q.text;
      KIND_MARK: begin
        word_d.out_byte   = 8'd0;
        word_d.byte_valid = 1'b0;
        word_d.error      = job_q.err && job_q.text_last;
      end
      KIND_REF: begin
        priority if (idx_q == 4'd0) word_d.out_byte = ChAmp;
        else if (idx_q == 4'd1)     word_d.out_byte = ChHash;
        else if (idx_q <= ndig + 4'd1) word_d.out_byte = ChZero | {4'd0, job_q.bcd[4*dpos +: 4]};
        else                        word_d.out_byte = ChSemi;
      end
      default: word_d.out_byte = ent_char(job_q.kind, idx_q, len);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (job_load_i) begin
        job_valid_q <= 1'b1;
        idx_q       <= '0;
      end else if (step && last_byte) begin
        job_valid_q <= 1'b0;
      end else if (step) begin
        idx_q <= idx_q + 4'd1;
      end
      if (step) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_load_i) job_q <= job_i;
    if (step) out_q <= word_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_q |-> idx_q < len)
    else $error("job index past its length");

  a_error_on_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.error) |-> (!out_word_o.byte_valid && out_word_o.text_end))
    else $error("error flag outside an end marker");

  a_end_is_run_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.text_end) |-> out_word_o.run_last)
    else $error("text end without run last");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_load_i |-> free_o)
    else $error("job loaded while busy");

endmodule

FILE: rtl/core/xml_text_escaper_core.sv
// XML text escaper: top level.
// Takes text one byte per word on the input channel (in_word_i: in_byte, text_last) and
// returns its XML-escaped form one byte per word on the output channel. '&', '<', '>'
// and, per quote_mode, quotes become named entities; control bytes and UTF-8 sequences
// become decimal references "&#N;". A text_last byte that makes no text yields a bare
// end marker (byte_valid 0), which carries error when the text held a bad sequence.
// quote_mode must be written through cfg_we_i/cfg_wdata_i only while the block is idle;
// the block does not enforce this. Each job is registered, then its output word.
// Throughput: one input word per cycle while each makes at most one output byte and the
// receiver takes the output; an escape of N bytes holds the input until its last byte
// is registered. UTF-8 lead and middle bytes are taken likewise, with no output.
// The UTF-8 value is gathered in BCD as it arrives, so references need no divider.
// Reset clears quote_mode, the sequence state and both valid flags.
// When the receiver stalls, the output word holds and the input stalls once the
// current escape job is waiting.
module xml_text_escaper_core
  import xte_pkg::*;
#(
  parameter int MaxSeqBytes = MaxSeqBytesDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  xte_in_t    in_word_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output xte_out_t   out_word_o
);

  logic     accept;
  logic     job_valid;
  xte_job_t job;
  logic     free;

  assign in_ready_o = free;
  assign accept     = in_valid_i && in_ready_o;

  xte_decode #(
    .MaxSeqBytes(MaxSeqBytes)
  ) u_decode (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_word_i  (in_word_i),
    .accept_i   (accept),
    .job_valid_o(job_valid),
    .job_o      (job)
  );

  xte_emit u_emit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_load_i (job_valid),
    .job_i      (job),
    .free_o     (free),
    .out_ready_i(out_ready_i),
    .out_valid_o(out_valid_o),
    .out_word_o (out_word_o)
  );

endmodule
